### design/fes_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fes_pkg
// Shared widths, reset values and register codes of the fire effect stencil.
// ----------------------------------------------------------------------------
package fes_pkg;

	localparam int HEAT_W    = 16;
	localparam int OVR_W     = 8;
	localparam int COL_W     = 10;
	localparam int LEVEL_W   = 8;
	localparam int DECAY_W   = 16;
	localparam int SHIFT_W   = 3;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 16;

	// sum / 4 * decay in Q0.16 is one shift by two plus sixteen
	localparam int DECAY_SHIFT = 18;

	localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd65339;
	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd3;
	localparam logic [HEAT_W-1:0]  HEAT_MAX    = 16'hFFFF;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 8'd255;

	localparam int PIPE_DEPTH = 6;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DECAY = 1'b0,
		CFG_SHIFT = 1'b1
	} cfg_reg_t;

endpackage

`default_nettype wire

### design/fes_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fes_if
// Valid/ready channels of the fire effect stencil: pixel items in, results out.
// ----------------------------------------------------------------------------
interface fes_in_if import fes_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [HEAT_W-1:0]  heat_value;
	logic [OVR_W-1:0]   override_value;
	logic [COL_W-1:0]   column;
	logic               bottom_row;

	modport source (output valid, output heat_value, output override_value,
		output column, output bottom_row, input ready);
	modport sink (input valid, input heat_value, input override_value,
		input column, input bottom_row, output ready);
endinterface

interface fes_out_if import fes_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [HEAT_W-1:0]  new_heat;
	logic [LEVEL_W-1:0] intensity;

	modport source (output valid, output new_heat, output intensity, input ready);
	modport sink (input valid, input new_heat, input intensity, output ready);
endinterface

`default_nettype wire

### design/fire_effect_stencil.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fire_effect_stencil
// Heat diffusion stencil over a streamed frame, rows from bottom to top.
//
// pixel carries one heat pixel per item (heat, override, column, bottom flag);
// result carries the new heat and the display intensity of that pixel, in
// order. Both are valid/ready channels; an item moves when valid and ready
// are high at a clock edge. cfg_we/cfg_index/cfg_data write the decay factor
// and the brightness shift; write them only while no item is in flight.
//
// Six register stages: input, line store read, neighbor sum, decay multiply,
// saturation, output register. One item is accepted every cycle unless a
// stalled receiver has filled the pipeline. The line store is three copies
// of two banks of LINE_WIDTH words so the left, centre and right neighbors
// are read together. Each stage advances when its successor is empty or
// moving, so bubbles close up and a stalled receiver fills the pipeline
// before pixel.ready drops; nothing is lost or repeated.
//
// Reset clears the valid bits, the bank select and the registers to their
// defaults. The line banks hold garbage until a full row has been written.
// ----------------------------------------------------------------------------
module fire_effect_stencil
	import fes_pkg::*;
#(
	parameter int LINE_WIDTH = 640,
	parameter int FRAC_BITS  = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data,
	fes_in_if.sink                    pixel,
	fes_out_if.source                 result
);

	localparam int IDX_W  = $clog2(LINE_WIDTH);
	localparam int OWN_W  = (OVR_W + FRAC_BITS > HEAT_W) ? OVR_W + FRAC_BITS : HEAT_W;
	localparam int SUM_W  = OWN_W + 2;
	localparam int PROD_W = SUM_W + DECAY_W;
	localparam int WIDE_W = HEAT_W + (1 << SHIFT_W) - 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINE_WIDTH - 1);

	// configuration
	logic [DECAY_W-1:0] decay_q;
	logic [SHIFT_W-1:0] shift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q <= DECAY_RESET;
			shift_q <= SHIFT_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_DECAY: decay_q <= cfg_data[DECAY_W-1:0];
				CFG_SHIFT: shift_q <= cfg_data[SHIFT_W-1:0];
				default:   ;
			endcase
		end
	end

	// stage control
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;

	always_comb begin
		adv6 = !v_s6 || result.ready;
		adv5 = !v_s5 || adv6;
		adv4 = !v_s4 || adv5;
		adv3 = !v_s3 || adv4;
		adv2 = !v_s2 || adv3;
		adv1 = !v_s1 || adv2;
	end

	assign pixel.ready = adv1;

	logic parity_q;
	logic row_end_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
			parity_q <= 1'b0;
		end else begin
			if (adv1) v_s1 <= pixel.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
			if (adv6) v_s6 <= v_s5;
			if (adv2 && v_s1 && row_end_s1) parity_q <= !parity_q;
		end
	end

	// stage 1: input register with column clamp
	logic [HEAT_W-1:0] heat_s1;
	logic [OVR_W-1:0]  ovr_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              bottom_s1;
	logic              col_over;

	assign col_over = (32'(pixel.column) >= 32'(LINE_WIDTH));

	always_ff @(posedge clk) begin
		if (adv1) begin
			heat_s1    <= pixel.heat_value;
			ovr_s1     <= pixel.override_value;
			idx_s1     <= col_over ? LAST_IDX : IDX_W'(pixel.column);
			bottom_s1  <= pixel.bottom_row;
		end
	end

	logic [IDX_W-1:0] left_idx, right_idx;

	always_comb begin
		row_end_s1 = (idx_s1 == LAST_IDX);
		left_idx   = (idx_s1 == '0) ? LAST_IDX : idx_s1 - IDX_W'(1);
		right_idx  = row_end_s1 ? '0 : idx_s1 + IDX_W'(1);
	end

	// stage 2: line store, read bank is parity_q, write bank the other one
	logic [HEAT_W-1:0] mem_l [2][LINE_WIDTH];
	logic [HEAT_W-1:0] mem_c [2][LINE_WIDTH];
	logic [HEAT_W-1:0] mem_r [2][LINE_WIDTH];
	logic [HEAT_W-1:0] left_s2, centre_s2, right_s2;
	logic [OWN_W-1:0]  own_s2;
	logic              bottom_s2;

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			mem_l[!parity_q][idx_s1] <= heat_s1;
			mem_c[!parity_q][idx_s1] <= heat_s1;
			mem_r[!parity_q][idx_s1] <= heat_s1;
		end
		if (adv2) begin
			left_s2   <= mem_l[parity_q][left_idx];
			centre_s2 <= mem_c[parity_q][idx_s1];
			right_s2  <= mem_r[parity_q][right_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			own_s2    <= (ovr_s1 != '0) ? (OWN_W'(ovr_s1) << FRAC_BITS) : OWN_W'(heat_s1);
			bottom_s2 <= bottom_s1;
		end
	end

	// stage 3: neighbor sum, bottom row sees zero below
	logic [SUM_W-1:0] sum_s3;

	always_ff @(posedge clk) begin
		if (adv3) begin
			if (bottom_s2) begin
				sum_s3 <= SUM_W'(own_s2);
			end else begin
				sum_s3 <= SUM_W'(left_s2) + SUM_W'(centre_s2) + SUM_W'(right_s2)
					+ SUM_W'(own_s2);
			end
		end
	end

	// stage 4: decay multiply
	logic [PROD_W-1:0] prod_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			prod_s4 <= PROD_W'(sum_s3) * PROD_W'(decay_q);
		end
	end

	// stage 5: scale and saturate
	logic [PROD_W-1:0] scaled;
	logic [HEAT_W-1:0] newh_s5;

	assign scaled = prod_s4 >> DECAY_SHIFT;

	always_ff @(posedge clk) begin
		if (adv5) begin
			newh_s5 <= (scaled > PROD_W'(HEAT_MAX)) ? HEAT_MAX : scaled[HEAT_W-1:0];
		end
	end

	// stage 6: display intensity and output register
	logic [WIDE_W-1:0]  wide;
	logic [WIDE_W-1:0]  level;
	logic [HEAT_W-1:0]  newh_s6;
	logic [LEVEL_W-1:0] inten_s6;

	always_comb begin
		wide  = WIDE_W'(newh_s5) << shift_q;
		level = wide >> FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (adv6) begin
			newh_s6  <= newh_s5;
			inten_s6 <= (level > WIDE_W'(LEVEL_MAX)) ? LEVEL_MAX : level[LEVEL_W-1:0];
		end
	end

	assign result.valid     = v_s6;
	assign result.new_heat  = newh_s6;
	assign result.intensity = inten_s6;

endmodule

`default_nettype wire

### design/fes_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fes_chk
// Port-level checks of the fire effect stencil, bound to the top level.
// ----------------------------------------------------------------------------
module fes_chk
	import fes_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [HEAT_W-1:0]  new_heat,
	input wire logic [LEVEL_W-1:0] intensity
);

	localparam int CNT_W = $clog2(PIPE_DEPTH + 1) + 1;

	logic [CNT_W-1:0] inflight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + CNT_W'(in_valid && in_ready)
				- CNT_W'(out_valid && out_ready);
		end
	end

	// items in flight never exceed the pipeline depth
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(PIPE_DEPTH))
		else $error("more items in flight than pipeline stages");

	// no result without an item inside
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("result shown with no item in flight");

	// input backpressure only when the output is stalled
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled while output is free");

	// zero heat shows as dark
	a_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && new_heat == '0 |-> intensity == '0)
		else $error("nonzero intensity for zero heat");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(new_heat) && $stable(intensity))
		else $error("stalled result changed");

endmodule

bind fire_effect_stencil fes_chk u_fes_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixel.valid),
	.in_ready  (pixel.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.new_heat  (result.new_heat),
	.intensity (result.intensity)
);

`default_nettype wire

### verif/fes_stencil_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fes_stencil_check
// Watches the pixel, result and register write ports of the fire effect
// stencil. Keeps its own pair of line banks, bank select and register copies,
// works out the new heat and display level of every accepted pixel item, and
// compares each accepted result item field by field with the oldest one still
// outstanding.
// ----------------------------------------------------------------------------
module fes_stencil_check
	import fes_pkg::*;
#(
	parameter int LINE_WIDTH = 640,
	parameter int FRAC_BITS  = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data,
	fes_in_if                         pix,
	fes_out_if                        res,
	output int                        pending,
	output int                        fail_count
);

	typedef struct packed {
		logic [HEAT_W-1:0]  heat;
		logic [LEVEL_W-1:0] level;
	} pixel_out_t;

	pixel_out_t         expected_heat_q[$];
	logic [HEAT_W-1:0]  bank_a [LINE_WIDTH];
	logic [HEAT_W-1:0]  bank_b [LINE_WIDTH];
	logic               row_odd;
	logic [DECAY_W-1:0] decay;
	logic [SHIFT_W-1:0] shift;

	initial fail_count = 0;

	task automatic report(input string what, input int got, input int want);
		$display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		int          col;
		int          lft;
		int          rgt;
		logic [35:0] acc;
		logic [35:0] cooled;
		logic [35:0] lvl;
		logic [HEAT_W-1:0] newh;
		pixel_out_t  want;
		if (!arst_n) begin
			row_odd = 1'b0;
			decay = DECAY_RESET;
			shift = SHIFT_RESET;
			expected_heat_q.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_DECAY: decay = cfg_data[DECAY_W-1:0];
					CFG_SHIFT: shift = cfg_data[SHIFT_W-1:0];
					default: ;
				endcase
			end
			if (res.valid && res.ready) begin
				if (expected_heat_q.size() == 0) begin
					report("result item with nothing outstanding", int'(res.new_heat), 0);
				end else begin
					want = expected_heat_q.pop_front();
					if (res.new_heat !== want.heat)
						report("new_heat", int'(res.new_heat), int'(want.heat));
					if (res.intensity !== want.level)
						report("intensity", int'(res.intensity), int'(want.level));
				end
			end
			if (pix.valid && pix.ready) begin
				col = (pix.column >= LINE_WIDTH) ? LINE_WIDTH - 1 : int'(pix.column);
				lft = (col == 0) ? LINE_WIDTH - 1 : col - 1;
				rgt = (col == LINE_WIDTH - 1) ? 0 : col + 1;
				// override heat is an integer, own heat is 8.8
				if (pix.override_value != '0)
					acc = {28'b0, pix.override_value} << FRAC_BITS;
				else
					acc = {20'b0, pix.heat_value};
				if (!pix.bottom_row) begin
					if (row_odd)
						acc = acc + bank_b[lft] + bank_b[col] + bank_b[rgt];
					else
						acc = acc + bank_a[lft] + bank_a[col] + bank_a[rgt];
				end
				cooled = (acc * {20'b0, decay}) >> DECAY_SHIFT;
				newh = (cooled > {20'b0, HEAT_MAX}) ? HEAT_MAX : cooled[HEAT_W-1:0];
				lvl = ({20'b0, newh} << shift) >> FRAC_BITS;
				want.heat = newh;
				want.level = (lvl > {28'b0, LEVEL_MAX}) ? LEVEL_MAX : lvl[LEVEL_W-1:0];
				expected_heat_q.push_back(want);
				// line store keeps the raw heat, never the override
				if (row_odd)
					bank_a[col] = pix.heat_value;
				else
					bank_b[col] = pix.heat_value;
				if (col == LINE_WIDTH - 1)
					row_odd = ~row_odd;
			end
			pending = expected_heat_q.size();
		end
	end

endmodule

`default_nettype wire

### verif/fire_effect_stencil_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fire_effect_stencil_tb
// Drives pixel items and register writes into the fire effect stencil and
// stalls the result side at random. Bottom row specials come first, then two
// complete rows fill both line banks, then wrap, clamp and register extremes,
// then random rows of random length under changing decay and shift settings.
// A separate checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module fire_effect_stencil_tb;
	import fes_pkg::*;

	localparam int LINE_WIDTH     = 640;
	localparam int FRAC_BITS      = 8;
	localparam int ITEM_TARGET    = 1900;
	localparam int SEG_ITEMS      = 120;
	localparam int CALM_TAIL      = 200;
	localparam int WATCHDOG_LIMIT = 2000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;
	logic                 sink_ready = 1'b0;
	int                   stall_left = 0;
	logic                 idle_on = 1'b1;
	int                   sent = 0;
	int                   quiet_cycles = 0;
	int                   pending;
	int                   fail_count;

	fes_in_if  pixel_ch ();
	fes_out_if result_ch ();

	assign result_ch.ready = sink_ready;

	always #2 clk = ~clk;

	fire_effect_stencil #(
		.LINE_WIDTH (LINE_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (pixel_ch),
		.result    (result_ch)
	);

	fes_stencil_check #(
		.LINE_WIDTH (LINE_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pix        (pixel_ch),
		.res        (result_ch),
		.pending    (pending),
		.fail_count (fail_count)
	);

	// result side stalls at random in bursts while idle_on is set
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			sink_ready <= 1'b0;
		end else if (idle_on && $urandom_range(7) == 0) begin
			stall_left <= $urandom_range(18, 0);
			sink_ready <= 1'b0;
		end else begin
			sink_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((pixel_ch.valid && pixel_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_pixel(input logic [HEAT_W-1:0] heat, input logic [OVR_W-1:0] ovr,
		input logic [COL_W-1:0] col, input logic bottom);
		if (idle_on && $urandom_range(7) == 0) begin
			pixel_ch.valid <= 1'b0;
			repeat ($urandom_range(19, 1)) @(posedge clk);
		end
		pixel_ch.valid          <= 1'b1;
		pixel_ch.heat_value     <= heat;
		pixel_ch.override_value <= ovr;
		pixel_ch.column         <= col;
		pixel_ch.bottom_row     <= bottom;
		do @(posedge clk); while (!pixel_ch.ready);
		sent++;
	endtask

	// a row ends on the last column or on a clamped one
	task automatic send_row(input int len, input logic bottom, input logic in_order);
		int                i;
		logic [HEAT_W-1:0] heat;
		logic [OVR_W-1:0]  ovr;
		logic [COL_W-1:0]  col;
		for (i = 0; i < len; i++) begin
			case ($urandom_range(7))
				0: heat = '0;
				1: heat = '1;
				default: heat = HEAT_W'($urandom_range(65535));
			endcase
			case ($urandom_range(7))
				0: ovr = '1;
				1, 2, 3: ovr = OVR_W'($urandom_range(255, 1));
				default: ovr = '0;
			endcase
			if (i == len - 1)
				col = ($urandom_range(2) == 0) ? COL_W'($urandom_range(1023, LINE_WIDTH))
					: COL_W'(LINE_WIDTH - 1);
			else if (in_order)
				col = COL_W'(i);
			else if ($urandom_range(3) == 0)
				col = ($urandom_range(1) == 0) ? COL_W'(0) : COL_W'(LINE_WIDTH - 2);
			else
				col = COL_W'($urandom_range(LINE_WIDTH - 2, 0));
			send_pixel(heat, ovr, col, bottom);
		end
	endtask

	task automatic drain();
		pixel_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic set_config(input logic [CFG_DAT_W-1:0] decay_val,
		input logic [CFG_DAT_W-1:0] shift_val);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DECAY;
		cfg_data  <= decay_val;
		@(posedge clk);
		cfg_index <= CFG_SHIFT;
		cfg_data  <= shift_val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int                 len;
		int                 seg_start;
		logic [DECAY_W-1:0] decay_pick;
		arst_n                  = 1'b0;
		cfg_we                  = 1'b0;
		cfg_index               = CFG_DECAY;
		cfg_data                = '0;
		pixel_ch.valid          = 1'b0;
		pixel_ch.heat_value     = '0;
		pixel_ch.override_value = '0;
		pixel_ch.column         = '0;
		pixel_ch.bottom_row     = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bottom row only: neighbors read zero, banks not yet filled
		send_pixel(16'h0000, 8'd0, 10'd0, 1'b1);
		send_pixel(16'hFFFF, 8'd0, 10'd1, 1'b1);
		send_pixel(16'h1234, 8'd255, 10'd2, 1'b1);
		send_pixel(16'hFFFF, 8'd1, 10'd3, 1'b1);
		send_pixel(16'h8000, 8'h7F, 10'd512, 1'b1);
		send_pixel(16'hAAAA, 8'd0, 10'(LINE_WIDTH - 1), 1'b1);
		send_pixel(16'h5555, 8'h80, 10'd1023, 1'b1);
		send_pixel(16'hFFFF, 8'd0, 10'(LINE_WIDTH), 1'b1);

		// two complete rows so that both banks hold written data
		send_row(LINE_WIDTH, 1'b1, 1'b1);
		send_row(LINE_WIDTH, 1'b0, 1'b1);

		drain();
		set_config(16'hFFFF, 16'd7);
		send_pixel(16'hFFFF, 8'd0, 10'd0, 1'b0);
		send_pixel(16'h00FF, 8'd255, 10'(LINE_WIDTH - 1), 1'b0);
		send_pixel(16'h1357, 8'd0, 10'd1023, 1'b0);
		send_pixel(16'h8000, 8'd1, 10'd320, 1'b0);

		drain();
		set_config(16'h0000, 16'hFFF8);
		send_pixel(16'hFFFF, 8'd255, 10'd0, 1'b0);
		send_pixel(16'h0000, 8'd0, 10'd5, 1'b0);
		send_pixel(16'hFFFF, 8'd0, 10'd700, 1'b0);
		send_pixel(16'h4242, 8'h10, 10'(LINE_WIDTH - 2), 1'b1);

		while (sent < ITEM_TARGET) begin
			drain();
			case ($urandom_range(3))
				0: decay_pick = '0;
				1: decay_pick = '1;
				2: decay_pick = DECAY_RESET;
				default: decay_pick = DECAY_W'($urandom_range(65535));
			endcase
			set_config(decay_pick, CFG_DAT_W'($urandom_range(65535)));
			idle_on = (sent < ITEM_TARGET - CALM_TAIL) ? ($urandom_range(3) != 0) : 1'b0;
			seg_start = sent;
			while (sent - seg_start < SEG_ITEMS && sent < ITEM_TARGET) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(200, 40) : $urandom_range(24, 1);
				send_row(len, $urandom_range(5) == 0, 1'b0);
			end
		end

		drain();
		repeat (PIPE_DEPTH + 4) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
